// ===== rtl/gsig_pkg.sv =====
// Shared constants, types and helper functions of the grid scan index generator.
// Depends on nothing; every other file of the block imports it.
package gsig_pkg;

  localparam int unsigned NUM_DIMS  = 6;
  localparam int unsigned SIZE_BITS = 10;
  localparam int unsigned IDX_W     = 60;
  localparam int unsigned CFG_W     = 60;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIDX_W    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_DIMS + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DIM_SIZES       = 2'd0;
  localparam cfg_idx_t CFG_NOMINAL_INDICES = 2'd1;
  localparam cfg_idx_t CFG_SCAN_MASK       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_MAC
  } gsig_state_e;

  typedef logic [NUM_DIMS-1:0][SIZE_BITS-1:0] dim_vec_t;

  typedef struct packed {
    logic load;
    logic advance;
  } odo_ctrl_t;

  // Size of one dimension; a configured size of zero counts as one.
  function automatic logic [SIZE_BITS-1:0] size_of(logic [CFG_W-1:0] sizes, int unsigned d);
    logic [SIZE_BITS-1:0] field;
    field = sizes[d*SIZE_BITS +: SIZE_BITS];
    return (field == '0) ? SIZE_BITS'(1) : field;
  endfunction

endpackage

// ===== rtl/gsig_if.sv =====
// Handshake channels of the grid scan index generator: advance requests in, indices out.
// Depends on gsig_pkg for the payload widths.
interface gsig_in_if import gsig_pkg::*;;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface gsig_out_if import gsig_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] linear_index;
  logic             last_entry;

  modport source (output valid, output linear_index, output last_entry, input ready);
  modport sink   (input valid, input linear_index, input last_entry, output ready);
endinterface

// ===== rtl/grid_scan_index_generator_unit.sv =====
// Grid scan index generator: an advance request walks a multi-dimensional grid as an odometer.
// Without restart an item goes from the idle state through the accumulate phase, paced by the
// shared multiplier visiting one dimension per cycle; a restart first adds a stride phase.
// The result sits in an output register, so a new request is taken while it waits.
// Asynchronous active-low reset clears configuration, counters, strides (to one) and control.
// Depends on gsig_pkg, gsig_if, gsig_mul_unit and gsig_odometer.
module grid_scan_index_generator_unit import gsig_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gsig_in_if.sink              in_ch,
  gsig_out_if.source           out_ch
);

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  logic [CFG_W-1:0]  dim_sizes_q;
  logic [CFG_W-1:0]  nominal_q;
  logic [MASK_W-1:0] scan_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_sizes_q <= '0;
      nominal_q   <= '0;
      scan_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIM_SIZES:       dim_sizes_q <= cfg_data_i;
        CFG_NOMINAL_INDICES: nominal_q   <= cfg_data_i;
        CFG_SCAN_MASK:       scan_mask_q <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state. The step counter walks the dimensions downwards while strides are
  // built, and upwards while the products are accumulated; one extra step in the
  // accumulate phase drains the multiplier and commits the result.
  gsig_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIDX_W-1:0] didx;

  logic [IDX_W-1:0] stride_q [NUM_DIMS];
  logic [IDX_W-1:0] acc_q, acc_d;
  logic             stride_we;
  logic [IDX_W-1:0] stride_wdata;

  logic                 mul_en;
  logic [IDX_W-1:0]     mul_a;
  logic [SIZE_BITS-1:0] mul_b;
  logic [IDX_W-1:0]     mul_p;

  odo_ctrl_t odo_ctrl;
  dim_vec_t  counters;
  logic      last;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;
  logic             out_load;
  logic [IDX_W-1:0] out_sum;
  logic             slot_free;

  assign didx      = cnt_q[DIDX_W-1:0];
  assign slot_free = !out_valid_q || out_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);

  gsig_mul_unit u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  gsig_odometer u_odo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (odo_ctrl),
    .dim_sizes_i (dim_sizes_q),
    .nominal_i   (nominal_q),
    .scan_mask_i (scan_mask_q),
    .counters_o  (counters),
    .last_o      (last)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    stride_we    = 1'b0;
    stride_wdata = mul_p;
    mul_en       = 1'b0;
    mul_a        = stride_q[didx];
    mul_b        = counters[didx];
    odo_ctrl     = '0;
    out_load     = 1'b0;
    out_sum      = acc_q + mul_p;

    unique case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.restart) begin
            // Counters take the start point now; strides follow over the next cycles.
            odo_ctrl.load = 1'b1;
            state_d       = ST_STRIDE;
            cnt_d         = CNT_W'(NUM_DIMS - 1);
          end else begin
            state_d = ST_MAC;
            cnt_d   = '0;
          end
        end
      end
      ST_STRIDE: begin
        // The product register carries the running product of the higher sizes.
        // The highest dimension always has stride one.
        stride_we    = 1'b1;
        stride_wdata = (cnt_q == CNT_W'(NUM_DIMS - 1)) ? IDX_W'(1) : mul_p;
        mul_en       = 1'b1;
        mul_a        = stride_wdata;
        mul_b        = size_of(dim_sizes_q, 32'(didx));
        if (cnt_q == '0) begin
          state_d = ST_MAC;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_MAC: begin
        if (cnt_q != CNT_W'(NUM_DIMS)) begin
          // Issue the product for this dimension while adding the previous one.
          mul_en = 1'b1;
          acc_d  = (cnt_q == '0) ? '0 : acc_q + mul_p;
          cnt_d  = cnt_q + CNT_W'(1);
        end else if (slot_free) begin
          // Last flag is taken from the counters before they step on.
          out_load         = 1'b1;
          odo_ctrl.advance = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Strides are one after reset, so a scan without any restart uses unit strides.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned d = 0; d < NUM_DIMS; d++) begin
        stride_q[d] <= IDX_W'(1);
      end
    end else if (stride_we) begin
      stride_q[didx] <= stride_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (out_load) begin
      out_idx_q  <= out_sum;
      out_last_q <= last;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.linear_index = out_idx_q;
  assign out_ch.last_entry   = out_last_q;

endmodule

// ===== rtl/gsig_mul_unit.sv =====
// Shared multiplier of the block: a 60-bit operand times a 10-bit operand, product registered.
// Depends on gsig_pkg for the widths.
module gsig_mul_unit import gsig_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [IDX_W-1:0]     a_i,
  input  logic [SIZE_BITS-1:0] b_i,
  output logic [IDX_W-1:0]     p_o
);

  logic [IDX_W+SIZE_BITS-1:0] prod;
  logic [IDX_W-1:0]           p_q;

  assign prod = a_i * b_i;

  // The product is kept modulo 2^60, as the linear index is.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod[IDX_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/gsig_odometer.sv =====
// Per-dimension counters of the grid scan: start-point load, odometer advance, last flag.
// Depends on gsig_pkg for widths, the control struct and size_of.
module gsig_odometer import gsig_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odo_ctrl_t         ctrl_i,
  input  logic [CFG_W-1:0]  dim_sizes_i,
  input  logic [CFG_W-1:0]  nominal_i,
  input  logic [MASK_W-1:0] scan_mask_i,
  output dim_vec_t          counters_o,
  output logic              last_o
);

  dim_vec_t cnt_q, cnt_d;
  dim_vec_t top;
  dim_vec_t start;
  dim_vec_t stepped;
  logic     last;

  always_comb begin
    logic                 carry;
    logic [SIZE_BITS-1:0] nom;
    carry   = 1'b1;
    last    = 1'b1;
    for (int unsigned d = 0; d < NUM_DIMS; d++) begin
      top[d] = size_of(dim_sizes_i, d) - SIZE_BITS'(1);
      nom    = nominal_i[d*SIZE_BITS +: SIZE_BITS];
      if (scan_mask_i[d]) begin
        start[d] = '0;
      end else begin
        start[d] = (nom > top[d]) ? top[d] : nom;
      end
      if (scan_mask_i[d] && (cnt_q[d] != top[d])) begin
        last = 1'b0;
      end
    end
    // Highest dimension moves fastest; carry ripples towards dimension 0.
    stepped = cnt_q;
    for (int d = NUM_DIMS - 1; d >= 0; d--) begin
      if (scan_mask_i[d] && carry) begin
        if (cnt_q[d] < top[d]) begin
          stepped[d] = cnt_q[d] + SIZE_BITS'(1);
          carry      = 1'b0;
        end else begin
          stepped[d] = '0;
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      cnt_d = start;
    end else if (ctrl_i.advance) begin
      cnt_d = stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign counters_o = cnt_q;
  assign last_o     = last;

endmodule
